// ----- rtl/core/gmds_pkg.sv -----
// Shared constants of the greedy minimum dispersion subset selector.
// No dependencies.
package gmds_pkg;
    localparam int IDX_W       = 6;
    localparam int DIST_W      = 24;
    localparam int DISP_W      = 30;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_RESULTS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 1'b1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_START = 1'b1;

    localparam logic [CFG_W-1:0] NUM_POINTS_RST  = 7'd64;
    localparam logic [CFG_W-1:0] SUBSET_SIZE_RST = 7'd2;
endpackage

// ----- rtl/core/gmds_if.sv -----
// Request, result and configuration channels of the subset selector.
// Depends on gmds_pkg.
interface gmds_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [gmds_pkg::IDX_W-1:0]  row_index;
    logic [gmds_pkg::IDX_W-1:0]  col_index;
    logic [gmds_pkg::DIST_W-1:0] distance_value;
    logic [gmds_pkg::IDX_W-1:0]  start_point;
    modport source (output valid, mode, row_index, col_index, distance_value, start_point,
                    input ready);
    modport sink (input valid, mode, row_index, col_index, distance_value, start_point,
                  output ready);
endinterface

interface gmds_out_if;
    logic                        valid;
    logic                        ready;
    logic [gmds_pkg::IDX_W-1:0]  point_index;
    logic [gmds_pkg::DISP_W-1:0] dispersion;
    logic                        last;
    logic                        error;
    modport source (output valid, point_index, dispersion, last, error, input ready);
    modport sink (input valid, point_index, dispersion, last, error, output ready);
endinterface

interface gmds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gmds_pkg::CFG_IDX_W-1:0] index;
    logic [gmds_pkg::CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gmds_dist_ram.sv -----
// Distance matrix store: one write port, one registered read port.
// Depends on gmds_pkg.
module gmds_dist_ram #(
    parameter int AW = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [gmds_pkg::DIST_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [gmds_pkg::DIST_W-1:0] o_rdata
);
    logic [gmds_pkg::DIST_W-1:0] mem [2**AW];
    logic [gmds_pkg::DIST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/greedy_min_dispersion_subset.sv -----
// Greedy minimum differential dispersion subset selector, top level.
// Depends on gmds_pkg, gmds_if and gmds_dist_ram.
// A write request writes both directions of the pair, one after the other, through the single
// write port of the distance RAM. A start request walks the RAMs, all reads being registered:
// with n points and m selected, every pick consists of the pick itself, a sum update over all
// points and the result; every pick after the first is preceded by a scan of the unchosen
// candidates against the chosen points; the final dispersion is taken over the m chosen points.
// A pick waits while the previous result is still unread. No request is taken during a run.
module greedy_min_dispersion_subset #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmds_in_if.sink     i_req,
    gmds_cfg_if.sink    i_cfg,
    gmds_out_if.source  o_res
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = IW + 1;
    localparam int AW = 2 * IW;
    localparam int DW = gmds_pkg::DISP_W;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_WR2     = 16'h0002,
        S_ERR     = 16'h0004,
        S_PICK    = 16'h0008,
        S_UPD_RD  = 16'h0010,
        S_UPD_WR  = 16'h0020,
        S_EMIT    = 16'h0040,
        S_CAND_RD = 16'h0080,
        S_CAND_A  = 16'h0100,
        S_CAND_S0 = 16'h0200,
        S_CAND_S1 = 16'h0400,
        S_CAND_S2 = 16'h0800,
        S_CAND_E  = 16'h1000,
        S_FIN_S0  = 16'h2000,
        S_FIN_S1  = 16'h4000,
        S_FIN_S2  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [gmds_pkg::CFG_W-1:0] r_num_points, r_subset_size;
    logic [IW-1:0]              r_pick, r_bpick, r_wrow, r_wcol;
    logic [gmds_pkg::DIST_W-1:0] r_wval;
    logic [CW-1:0]              r_j, r_s, r_cnt;
    logic                       r_first, r_have;
    logic [DW-1:0]              r_best, r_mx, r_mn;

    logic                       r_out_valid, r_out_last, r_out_err;
    logic [gmds_pkg::IDX_W-1:0] r_out_pt;
    logic [DW-1:0]              r_out_disp;

    logic [DW-1:0] acc_mem [MAX_POINTS];
    logic [IW-1:0] list_mem [MAX_POINTS];
    logic          flag_mem [MAX_POINTS];
    logic [DW-1:0] r_acc_q;
    logic [IW-1:0] r_list_q;
    logic          r_flag_q;

    logic                        w_dist_we;
    logic [AW-1:0]               w_dist_waddr, w_dist_raddr;
    logic [gmds_pkg::DIST_W-1:0] w_dist_wdata, w_dist_q;
    logic [IW-1:0]               w_acc_raddr, w_j_idx, w_req_row, w_req_col;
    logic                        w_req_acc, w_out_free, w_out_load, w_bad, w_row_ok;
    logic [CW-1:0]               w_n, w_m;
    logic [DW-1:0]               w_dj, w_disp;

    assign w_j_idx    = r_j[IW-1:0];
    assign w_n        = CW'(r_num_points);
    assign w_m        = CW'(r_subset_size);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_out_load = w_out_free && ((r_state == S_ERR)
                        || (r_state == S_EMIT && r_cnt != w_m)
                        || (r_state == S_FIN_S0 && r_s == r_cnt));
    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_req_row  = IW'(i_req.row_index);
    assign w_req_col  = IW'(i_req.col_index);
    assign w_row_ok   = (int'(i_req.row_index) < MAX_POINTS)
                        && (int'(i_req.col_index) < MAX_POINTS);
    assign w_bad = (r_num_points < 7'd2) || (int'(r_num_points) > MAX_POINTS)
                   || (r_subset_size < 7'd2) || (r_subset_size > r_num_points)
                   || (int'(r_subset_size) > gmds_pkg::MAX_RESULTS)
                   || (int'(i_req.start_point) >= int'(r_num_points));
    assign w_dj   = r_acc_q + DW'(w_dist_q);
    assign w_disp = r_mx - r_mn;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.point_index = r_out_pt;
    assign o_res.dispersion  = r_out_disp;
    assign o_res.last        = r_out_last;
    assign o_res.error       = r_out_err;

    // distance RAM ports and partial sum read address
    always_comb begin
        w_dist_we    = 1'b0;
        w_dist_waddr = {w_req_row, w_req_col};
        w_dist_wdata = i_req.distance_value;
        if (r_state == S_IDLE) begin
            w_dist_we = w_req_acc && (i_req.mode == gmds_pkg::MODE_WRITE) && w_row_ok;
        end else if (r_state == S_WR2) begin
            w_dist_we    = 1'b1;
            w_dist_waddr = {r_wcol, r_wrow};
            w_dist_wdata = r_wval;
        end
        if (r_state == S_UPD_RD) begin
            w_dist_raddr = {w_j_idx, r_pick};
        end else begin
            w_dist_raddr = {r_list_q, w_j_idx};
        end
        if (r_state == S_CAND_S1 || r_state == S_FIN_S1) begin
            w_acc_raddr = r_list_q;
        end else begin
            w_acc_raddr = w_j_idx;
        end
    end

    gmds_dist_ram #(.AW(AW)) u_dist (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_dist_waddr),
        .i_wdata (w_dist_wdata),
        .i_raddr (w_dist_raddr),
        .o_rdata (w_dist_q)
    );

    // partial sums, chosen list and chosen flags; flags are rewritten by the first sum pass
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD_WR) begin
            if (w_j_idx != r_pick) begin
                acc_mem[w_j_idx] <= r_first ? DW'(w_dist_q) : w_dj;
            end else if (r_first) begin
                acc_mem[w_j_idx] <= '0;
            end
            if (r_first) begin
                flag_mem[w_j_idx] <= (w_j_idx == r_pick);
            end
        end
        if (r_state == S_PICK) begin
            list_mem[r_cnt[IW-1:0]] <= r_pick;
            flag_mem[r_pick]        <= 1'b1;
        end
        r_acc_q  <= acc_mem[w_acc_raddr];
        r_list_q <= list_mem[r_s[IW-1:0]];
        r_flag_q <= flag_mem[w_j_idx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    if (i_req.mode == gmds_pkg::MODE_WRITE) begin
                        n_state = w_row_ok ? S_WR2 : S_IDLE;
                    end else begin
                        n_state = w_bad ? S_ERR : S_PICK;
                    end
                end
            end
            S_WR2:     n_state = S_IDLE;
            S_ERR:     n_state = w_out_free ? S_IDLE : S_ERR;
            S_PICK:    n_state = S_UPD_RD;
            S_UPD_RD:  n_state = (r_j == w_n) ? S_EMIT : S_UPD_WR;
            S_UPD_WR:  n_state = S_UPD_RD;
            S_EMIT: begin
                if (r_cnt == w_m) begin
                    n_state = S_FIN_S0;
                end else if (w_out_free) begin
                    n_state = S_CAND_RD;
                end
            end
            S_CAND_RD: n_state = (r_j == w_n) ? S_PICK : S_CAND_A;
            S_CAND_A:  n_state = r_flag_q ? S_CAND_RD : S_CAND_S0;
            S_CAND_S0: n_state = (r_s == r_cnt) ? S_CAND_E : S_CAND_S1;
            S_CAND_S1: n_state = S_CAND_S2;
            S_CAND_S2: n_state = S_CAND_S0;
            S_CAND_E:  n_state = S_CAND_RD;
            S_FIN_S0: begin
                if (r_s == r_cnt) begin
                    n_state = w_out_free ? S_IDLE : S_FIN_S0;
                end else begin
                    n_state = S_FIN_S1;
                end
            end
            S_FIN_S1:  n_state = S_FIN_S2;
            S_FIN_S2:  n_state = S_FIN_S0;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_points  <= gmds_pkg::NUM_POINTS_RST;
            r_subset_size <= gmds_pkg::SUBSET_SIZE_RST;
            r_out_valid   <= 1'b0;
            r_j           <= '0;
            r_s           <= '0;
            r_cnt         <= '0;
            r_first       <= 1'b0;
            r_have        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == gmds_pkg::CFG_NUM_POINTS) begin
                    r_num_points <= i_cfg.data;
                end else begin
                    r_subset_size <= i_cfg.data;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_wrow <= w_req_row;
                    r_wcol <= w_req_col;
                    r_wval <= i_req.distance_value;
                    r_pick <= IW'(i_req.start_point);
                    r_cnt  <= '0;
                    r_first <= 1'b1;
                end
                S_ERR: begin
                    if (w_out_load) begin
                        r_out_pt    <= '0;
                        r_out_disp  <= '0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                    end
                end
                S_PICK: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_j   <= '0;
                end
                S_UPD_WR: r_j <= r_j + 1'b1;
                S_EMIT: begin
                    r_s <= '0;
                    if (w_out_load) begin
                        r_out_pt    <= gmds_pkg::IDX_W'(r_pick);
                        r_out_disp  <= '0;
                        r_out_last  <= 1'b0;
                        r_out_err   <= 1'b0;
                        r_first     <= 1'b0;
                        r_have      <= 1'b0;
                        r_j         <= '0;
                    end
                end
                S_CAND_RD: begin
                    if (r_j == w_n) begin
                        r_pick <= r_bpick;
                    end
                end
                S_CAND_A: begin
                    if (r_flag_q) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_mx <= r_acc_q;
                        r_mn <= r_acc_q;
                        r_s  <= '0;
                    end
                end
                S_CAND_S2: begin
                    if (w_dj > r_mx) r_mx <= w_dj;
                    if (w_dj < r_mn) r_mn <= w_dj;
                    r_s <= r_s + 1'b1;
                end
                S_CAND_E: begin
                    if (!r_have || w_disp < r_best) begin
                        r_best  <= w_disp;
                        r_bpick <= w_j_idx;
                        r_have  <= 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                end
                S_FIN_S0: begin
                    if (w_out_load) begin
                        r_out_pt    <= gmds_pkg::IDX_W'(r_pick);
                        r_out_disp  <= w_disp;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b0;
                    end
                end
                // final dispersion: sum of one chosen point per pass
                S_FIN_S2: begin
                    if (r_s == '0) begin
                        r_mx <= r_acc_q;
                        r_mn <= r_acc_q;
                    end else begin
                        if (r_acc_q > r_mx) r_mx <= r_acc_q;
                        if (r_acc_q < r_mn) r_mn <= r_acc_q;
                    end
                    r_s <= r_s + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // a candidate that is scored is never a point already in the subset
    a_cand_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAND_E) |-> !r_flag_q)
        else $error("chosen point scored");

    // the chosen flag is set once a pick is taken
    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |=> flag_mem[$past(r_pick)])
        else $error("flag not set after pick");

    // a result is only loaded when the result register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_out_pt) && $stable(r_out_disp))
        else $error("result overwritten");

    // the run never selects more points than requested
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_CAND_RD) |-> (r_cnt <= w_m))
        else $error("selection count overrun");
endmodule
